[design/epsg_pkg.sv]
`default_nettype none

package epsg_pkg;

  localparam int COORD_BITS_DEF = 16;

  // Angles in degrees; the largest is 360 + 90 for the cosine lookup.
  localparam int ANG_BITS  = 9;
  localparam int STEP_BITS = 6;
  localparam int TRIG_BITS = 10;

  localparam logic [ANG_BITS-1:0] FULL_TURN    = 9'd360;
  localparam logic [ANG_BITS-1:0] HALF_TURN    = 9'd180;
  localparam logic [ANG_BITS-1:0] QUARTER_TURN = 9'd90;
  localparam logic [ANG_BITS-1:0] THREE_QUARTER_TURN = 9'd270;

  localparam logic [STEP_BITS-1:0] STEP_LARGE  = 6'd12;
  localparam logic [STEP_BITS-1:0] STEP_MEDIUM = 6'd15;
  localparam logic [STEP_BITS-1:0] STEP_SMALL  = 6'd20;
  localparam logic [STEP_BITS-1:0] STEP_TINY   = 6'd45;

  localparam logic [8:0] SIZE_LARGE  = 9'd128;
  localparam logic [8:0] SIZE_MEDIUM = 9'd32;
  localparam logic [8:0] SIZE_SMALL  = 9'd12;

  // Product rounding offset, half of 256.
  localparam logic signed [18:0] ROUND_HALF = 19'sd128;

  // 256 * sin(d) rounded, for d from 0 to 90 degrees.
  localparam logic [8:0] SIN_Q1 [0:90] = '{
    9'd0,   9'd4,   9'd9,   9'd13,  9'd18,  9'd22,  9'd27,  9'd31,  9'd36,  9'd40,
    9'd44,  9'd49,  9'd53,  9'd58,  9'd62,  9'd66,  9'd71,  9'd75,  9'd79,  9'd83,
    9'd88,  9'd92,  9'd96,  9'd100, 9'd104, 9'd108, 9'd112, 9'd116, 9'd120, 9'd124,
    9'd128, 9'd132, 9'd136, 9'd139, 9'd143, 9'd147, 9'd150, 9'd154, 9'd158, 9'd161,
    9'd165, 9'd168, 9'd171, 9'd175, 9'd178, 9'd181, 9'd184, 9'd187, 9'd190, 9'd193,
    9'd196, 9'd199, 9'd202, 9'd204, 9'd207, 9'd210, 9'd212, 9'd215, 9'd217, 9'd219,
    9'd222, 9'd224, 9'd226, 9'd228, 9'd230, 9'd232, 9'd234, 9'd236, 9'd237, 9'd239,
    9'd241, 9'd242, 9'd243, 9'd245, 9'd246, 9'd247, 9'd248, 9'd249, 9'd250, 9'd251,
    9'd252, 9'd253, 9'd254, 9'd254, 9'd255, 9'd255, 9'd255, 9'd256, 9'd256, 9'd256,
    9'd256
  };

  typedef struct packed {
    logic signed [15:0] center_x;
    logic signed [15:0] center_y;
    logic        [7:0]  radius_x;
    logic        [7:0]  radius_y;
  } in_item_t;

  typedef struct packed {
    logic signed [15:0] start_x;
    logic signed [15:0] start_y;
    logic signed [15:0] end_x;
    logic signed [15:0] end_y;
    logic               last_segment;
  } out_item_t;

  typedef struct packed {
    logic load;
    logic trig;
    logic mul;
    logic emit;
  } cmd_t;

  typedef struct packed {
    logic out_free;
    logic last;
  } sts_t;

  // 256 * sin(deg) for deg up to 450.
  function automatic logic signed [TRIG_BITS-1:0] sin256(input logic [ANG_BITS-1:0] deg);
    logic [ANG_BITS-1:0] a;
    logic [ANG_BITS-1:0] idx;
    logic                neg;
    begin
      a = (deg >= FULL_TURN) ? deg - FULL_TURN : deg;
      if (a <= QUARTER_TURN) begin
        idx = a;
        neg = 1'b0;
      end else if (a <= HALF_TURN) begin
        idx = HALF_TURN - a;
        neg = 1'b0;
      end else if (a <= THREE_QUARTER_TURN) begin
        idx = a - HALF_TURN;
        neg = 1'b1;
      end else begin
        idx = FULL_TURN - a;
        neg = 1'b1;
      end
      if (neg) begin
        return -$signed({1'b0, SIN_Q1[idx[6:0]]});
      end
      return $signed({1'b0, SIN_Q1[idx[6:0]]});
    end
  endfunction

  function automatic logic [STEP_BITS-1:0] angle_step(input logic [7:0] rx,
                                                      input logic [7:0] ry);
    logic [8:0] size;
    begin
      size = {1'b0, rx} + {1'b0, ry};
      if (size >= SIZE_LARGE) begin
        return STEP_LARGE;
      end else if (size >= SIZE_MEDIUM) begin
        return STEP_MEDIUM;
      end else if (size >= SIZE_SMALL) begin
        return STEP_SMALL;
      end
      return STEP_TINY;
    end
  endfunction

endpackage

`default_nettype wire

[design/epsg_ctrl.sv]
`default_nettype none

module epsg_ctrl (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          in_valid,
  output logic               in_stall,
  input  epsg_pkg::sts_t     sts,
  output epsg_pkg::cmd_t     cmd
);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_TRIG = 2'd1;
  localparam logic [1:0] ST_MUL  = 2'd2;
  localparam logic [1:0] ST_EMIT = 2'd3;

  logic [1:0] state_r;
  logic [1:0] state_nxt;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = ST_TRIG;
        end
      end
      ST_TRIG: begin
        cmd.trig  = 1'b1;
        state_nxt = ST_MUL;
      end
      ST_MUL: begin
        cmd.mul   = 1'b1;
        state_nxt = ST_EMIT;
      end
      ST_EMIT: begin
        // Hold here until the output register can take the next segment.
        if (sts.out_free) begin
          cmd.emit  = 1'b1;
          state_nxt = sts.last ? ST_IDLE : ST_TRIG;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  assign in_stall = (state_r != ST_IDLE);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

`ifndef ASSERT_OFF
  a_cmd_onehot: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0({cmd.load, cmd.trig, cmd.mul, cmd.emit}))
    else $error("more than one datapath command at once");

  a_last_returns_idle: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.emit && sts.last |=> !in_stall)
    else $error("controller did not return to idle after the final segment");

  a_load_starts_trig: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load |=> cmd.trig)
    else $error("lookup did not follow a new ellipse");
`endif

endmodule

`default_nettype wire

[design/epsg_datapath.sv]
`default_nettype none

module epsg_datapath #(
  parameter int COORD_BITS = epsg_pkg::COORD_BITS_DEF
) (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  epsg_pkg::in_item_t   in_item,
  input  epsg_pkg::cmd_t       cmd,
  output epsg_pkg::sts_t       sts,
  output logic                 out_valid,
  input  wire logic            out_stall,
  output epsg_pkg::out_item_t  out_item
);

  localparam int EXT_BITS  = (COORD_BITS > 16) ? COORD_BITS : 16;
  localparam int ANG_BITS  = epsg_pkg::ANG_BITS;
  localparam int TRIG_BITS = epsg_pkg::TRIG_BITS;

  logic [COORD_BITS-1:0] cx_r, cy_r, px_r, py_r;
  logic [7:0]            rx_r, ry_r;
  logic [epsg_pkg::STEP_BITS-1:0] step_r;
  logic [ANG_BITS-1:0]   ang_r;
  logic signed [TRIG_BITS-1:0] cos_r, sin_r;
  logic signed [18:0]    prodx_r, prody_r;
  logic                  out_valid_r;
  epsg_pkg::out_item_t   out_r;

  logic [EXT_BITS-1:0]   cx_ext, cy_ext;
  logic [COORD_BITS-1:0] cx_in, cy_in;
  logic signed [18:0]    sumx, sumy;
  logic signed [9:0]     dx, dy;
  logic [COORD_BITS-1:0] nx, ny;
  logic [ANG_BITS:0]     ang_next;

  // Centers are sign extended, then wrapped to the coordinate width.
  assign cx_ext = EXT_BITS'(in_item.center_x);
  assign cy_ext = EXT_BITS'(in_item.center_y);
  assign cx_in  = cx_ext[COORD_BITS-1:0];
  assign cy_in  = cy_ext[COORD_BITS-1:0];

  // floor((p + 128) / 256); the sum never exceeds 18 signed bits.
  assign sumx = prodx_r + epsg_pkg::ROUND_HALF;
  assign sumy = prody_r + epsg_pkg::ROUND_HALF;
  assign dx   = sumx[17:8];
  assign dy   = sumy[17:8];
  assign nx   = cx_r + COORD_BITS'(dx);
  assign ny   = cy_r + COORD_BITS'(dy);

  assign ang_next     = {1'b0, ang_r} + (ANG_BITS + 1)'(step_r);
  assign sts.last     = (ang_next > {1'b0, epsg_pkg::FULL_TURN});
  assign sts.out_free = !out_valid_r || !out_stall;

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      cx_r   <= cx_in;
      cy_r   <= cy_in;
      rx_r   <= in_item.radius_x;
      ry_r   <= in_item.radius_y;
      step_r <= epsg_pkg::angle_step(in_item.radius_x, in_item.radius_y);
      ang_r  <= '0;
      px_r   <= cx_in + COORD_BITS'(in_item.radius_x);
      py_r   <= cy_in;
    end
    if (cmd.trig) begin
      cos_r <= epsg_pkg::sin256(ang_r + epsg_pkg::QUARTER_TURN);
      sin_r <= epsg_pkg::sin256(ang_r);
    end
    if (cmd.mul) begin
      prodx_r <= 19'($signed({1'b0, rx_r})) * 19'(cos_r);
      prody_r <= 19'($signed({1'b0, ry_r})) * 19'(sin_r);
    end
    if (cmd.emit) begin
      out_r.start_x      <= 16'(EXT_BITS'(px_r));
      out_r.start_y      <= 16'(EXT_BITS'(py_r));
      out_r.end_x        <= 16'(EXT_BITS'(nx));
      out_r.end_y        <= 16'(EXT_BITS'(ny));
      out_r.last_segment <= sts.last;
      px_r               <= nx;
      py_r               <= ny;
      ang_r              <= ang_next[ANG_BITS-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.emit) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  assign out_valid = out_valid_r;
  assign out_item  = out_r;

`ifndef ASSERT_OFF
  a_emit_into_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.emit |-> sts.out_free)
    else $error("segment written over an untaken result");

  a_angle_range: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.trig || cmd.mul || cmd.emit) |-> ang_r <= epsg_pkg::FULL_TURN)
    else $error("angle ran past a full turn");

  a_load_clears_angle: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load |=> ang_r == '0)
    else $error("angle not cleared for a new ellipse");
`endif

endmodule

`default_nettype wire

[design/ellipse_polygon_segment_gen.sv]
// Ellipse polygon segment generator. Each input transaction carries an ellipse
// center and two radii; the block answers with 9, 19, 25 or 31 output
// transactions (angle step 45, 20, 15 or 12 degrees, chosen from radius_x +
// radius_y), each a straight segment from the previous point to the next one
// on the ellipse, with last_segment set on the final one. One ellipse is
// worked at a time: the input is taken when the block is idle, and each
// segment then passes in turn through the sine table lookup, the two radius
// products, and the rounding and coordinate add, waiting while the output
// is stalled. The final segment can wait in the output register while the
// next ellipse is accepted. Coordinates wrap at COORD_BITS bits.
`default_nettype none

module ellipse_polygon_segment_gen #(
  parameter int COORD_BITS = epsg_pkg::COORD_BITS_DEF
) (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            in_valid,
  output logic                 in_stall,
  input  epsg_pkg::in_item_t   in_item,
  output logic                 out_valid,
  input  wire logic            out_stall,
  output epsg_pkg::out_item_t  out_item
);

  epsg_pkg::cmd_t cmd;
  epsg_pkg::sts_t sts;

  epsg_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .sts      (sts),
    .cmd      (cmd)
  );

  epsg_datapath #(
    .COORD_BITS (COORD_BITS)
  ) u_datapath (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_item   (in_item),
    .cmd       (cmd),
    .sts       (sts),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_item  (out_item)
  );

endmodule

`default_nettype wire
